/* hw/rtl/lruc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared types and constants of the LRU keyed cache.
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int FUNC_W          = 3;
    localparam int STATUS_W        = 4;
    localparam int LIMIT_W         = 5;
    localparam int OUT_KEY_W       = 32;
    localparam int OUT_VAL_W       = 32;
    localparam int CNT_OUT_W       = 5;

    localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_GET    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_TRIM   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 4'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_HIT      = 4'd2;
    localparam logic [STATUS_W-1:0] ST_MISS     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_NULL     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_TRIMMED  = 4'd8;

    localparam logic [7:0] ADDR_LIMIT = 8'd0;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input transaction
        logic search;   // key match / oldest search
        logic touch;    // refresh matched slot
        logic insert;   // write new entry into free slot
        logic evict;    // drop oldest slot
        logic drop;     // drop matched slot
        logic clear;
        logic upd;      // store handle into matched slot
    } lruc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic full;     // count >= limit
        logic over;     // count > limit
        logic null_h;
        logic [FUNC_W-1:0] func;
    } lruc_sts_t;

endpackage

/* hw/rtl/lruc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_datapath
// Slot store, key match, recency ranks and result fields.
// ----------------------------------------------------------------------------
module lruc_datapath import lruc_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lruc_cmd_t              cmd,
    output lruc_sts_t              sts,
    input  logic [FUNC_W-1:0]      in_func,
    input  logic [KEY_BITS-1:0]    in_key,
    input  logic [HANDLE_BITS-1:0] in_handle,
    input  logic [LIMIT_W-1:0]     limit,
    output logic [OUT_VAL_W-1:0]   rd_value,
    output logic [OUT_KEY_W-1:0]   ev_key,
    output logic [CNT_OUT_W-1:0]   ev_count,
    output logic [CNT_OUT_W-1:0]   occupancy
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CAPACITY-1:0]    valid_reg;
    logic [KEY_BITS-1:0]    key_reg    [CAPACITY];
    logic [HANDLE_BITS-1:0] handle_reg [CAPACITY];
    logic [IW-1:0]          rank_reg   [CAPACITY];
    logic [CW-1:0]          count_reg;
    logic [FUNC_W-1:0]      func_reg;
    logic [KEY_BITS-1:0]    lkey_reg;
    logic [HANDLE_BITS-1:0] lhandle_reg;
    logic [IW-1:0]          hit_idx_reg, old_idx_reg, free_idx_reg;
    logic                   hit_reg;
    logic [OUT_VAL_W-1:0]   rd_reg;
    logic [OUT_KEY_W-1:0]   ekey_reg;
    logic [CNT_OUT_W-1:0]   ecnt_reg;

    logic [CAPACITY-1:0] match;
    logic [IW-1:0] hit_idx, old_idx, free_idx;
    logic [CW-1:0] lim_eff;

    always_comb begin
        lim_eff = CW'(CAPACITY);
        if (limit == '0) begin
            lim_eff = CW'(1);
        end else if (32'(limit) < 32'(CAPACITY)) begin
            lim_eff = CW'(limit);
        end
    end

    // match of key, oldest valid (unique max rank), first free
    always_comb begin
        hit_idx  = '0;
        old_idx  = '0;
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            match[i] = valid_reg[i] && (key_reg[i] == lkey_reg);
            if (match[i]) begin
                hit_idx = IW'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = IW'(i);
            end
            if (valid_reg[i] && rank_reg[i] == IW'(count_reg - CW'(1))) begin
                old_idx = IW'(i);
            end
        end
    end

    assign sts.hit    = hit_reg;
    assign sts.full   = count_reg >= lim_eff;
    assign sts.over   = count_reg > lim_eff;
    assign sts.null_h = lhandle_reg == '0;
    assign sts.func   = func_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.load) begin
                func_reg    <= in_func;
                lkey_reg    <= in_key;
                lhandle_reg <= in_handle;
                rd_reg      <= '0;
                ekey_reg    <= '0;
                ecnt_reg    <= '0;
            end
            if (cmd.search) begin
                hit_reg      <= |match;
                hit_idx_reg  <= hit_idx;
                old_idx_reg  <= old_idx;
                free_idx_reg <= free_idx;
            end
            if (cmd.upd) begin
                handle_reg[hit_idx_reg] <= lhandle_reg;
            end
            if (cmd.touch) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (valid_reg[i] && rank_reg[i] < rank_reg[hit_idx_reg]) begin
                        rank_reg[i] <= rank_reg[i] + IW'(1);
                    end
                end
                rank_reg[hit_idx_reg] <= '0;
                if (!cmd.upd) begin
                    rd_reg <= OUT_VAL_W'(handle_reg[hit_idx_reg]);
                end
            end
            if (cmd.drop || cmd.evict) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (valid_reg[i] && rank_reg[i] >
                            rank_reg[cmd.evict ? old_idx_reg : hit_idx_reg]) begin
                        rank_reg[i] <= rank_reg[i] - IW'(1);
                    end
                end
                valid_reg[cmd.evict ? old_idx_reg : hit_idx_reg] <= 1'b0;
                count_reg <= count_reg - CW'(1);
                if (cmd.evict) begin
                    ekey_reg <= OUT_KEY_W'(key_reg[old_idx_reg]);
                    ecnt_reg <= ecnt_reg + CNT_OUT_W'(1);
                end
            end
            if (cmd.insert) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (valid_reg[i]) begin
                        rank_reg[i] <= rank_reg[i] + IW'(1);
                    end
                end
                valid_reg[free_idx_reg]  <= 1'b1;
                key_reg[free_idx_reg]    <= lkey_reg;
                handle_reg[free_idx_reg] <= lhandle_reg;
                rank_reg[free_idx_reg]   <= '0;
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.clear) begin
                valid_reg <= '0;
                count_reg <= '0;
            end
        end
    end

    assign rd_value  = rd_reg;
    assign ev_key    = ekey_reg;
    assign ev_count  = ecnt_reg;
    assign occupancy = CNT_OUT_W'(count_reg);

endmodule

/* hw/rtl/lruc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruc_ctrl
// Operation sequencer and output register handshake.
// ----------------------------------------------------------------------------
module lruc_ctrl import lruc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output lruc_cmd_t           cmd,
    input  lruc_sts_t           sts,
    output logic [STATUS_W-1:0] status
);
    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_DECIDE, S_EVICT, S_RESEARCH, S_INSERT, S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                mv_reg, mv_next;

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign status  = status_reg;

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        mv_next     = mv_reg && !m_ready;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                state_next = S_OUT;
                unique case (sts.func)
                    FN_ADD: begin
                        if (sts.null_h) begin
                            status_next = ST_NULL;
                        end else if (sts.hit) begin
                            cmd.upd = 1'b1;
                            cmd.touch = 1'b1;
                            status_next = ST_UPDATED;
                        end else if (sts.full) begin
                            cmd.evict = 1'b1;
                            state_next = S_RESEARCH;
                        end else begin
                            state_next = S_INSERT;
                        end
                    end
                    FN_GET: begin
                        if (sts.hit) begin
                            cmd.touch = 1'b1;
                            status_next = ST_HIT;
                        end else begin
                            status_next = ST_MISS;
                        end
                    end
                    FN_REMOVE: begin
                        if (sts.hit) begin
                            cmd.drop = 1'b1;
                            status_next = ST_REMOVED;
                        end else begin
                            status_next = ST_ABSENT;
                        end
                    end
                    FN_CLEAR: begin
                        cmd.clear = 1'b1;
                        status_next = ST_CLEARED;
                    end
                    FN_TRIM: begin
                        status_next = ST_TRIMMED;
                        if (sts.over) begin
                            state_next = S_EVICT;
                        end
                    end
                    default: status_next = ST_MISS;
                endcase
            end
            S_EVICT: begin
                // trim loop: search then evict while over limit
                cmd.search = 1'b1;
                state_next = S_DECIDE;
                if (sts.over) begin
                    state_next = S_SEARCH;
                end
            end
            S_RESEARCH: begin
                cmd.search = 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT: begin
                cmd.insert  = 1'b1;
                status_next = ST_INSERTED;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!mv_reg) begin
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_SEARCH && sts.func == FN_TRIM && status_reg == ST_TRIMMED
                && sts.over) begin
            // continuing trim pass: oldest found, evict it next
            cmd.search = 1'b1;
            state_next = S_EVICT;
        end
        if (state_reg == S_EVICT) begin
            cmd = '0;
            cmd.evict  = 1'b1;
            state_next = S_SEARCH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_MISS;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= cmd.load ? ST_MISS : status_next;
            mv_reg     <= mv_next;
        end
    end

endmodule

/* hw/rtl/lru_keyed_cache_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_keyed_cache_core
// Fully associative key-to-handle cache with LRU replacement.
// ----------------------------------------------------------------------------
// Sequencing (accept to m_tvalid): get/remove/clear/update/null/unknown pass search
//   and decide; insert also passes S_INSERT, with eviction S_RESEARCH first; trim
//   passes S_EVICT and S_SEARCH per evicted entry. One transaction at a time;
//   the next is accepted the cycle after the result is taken.
// Reset: aresetn synchronous active low; all slots invalid, limit 16.
// ----------------------------------------------------------------------------
module lru_keyed_cache_core import lruc_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[2:0], lookup_key, entry_value, zero pad
    input  logic [((FUNC_W+KEY_BITS+HANDLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[3:0], read_value[35:4], evicted_flag[36], evicted_key[68:37],
    // evicted_count[73:69], occupancy[78:74], zero pad
    output logic [79:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    lruc_cmd_t           cmd;
    lruc_sts_t           sts;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [STATUS_W-1:0] status;
    logic [OUT_VAL_W-1:0] rd_value;
    logic [OUT_KEY_W-1:0] ev_key;
    logic [CNT_OUT_W-1:0] ev_count, occupancy;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LIMIT[1:0]) ? 32'(limit_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_W'(16);
        end else if (psel && penable && pwrite && paddr == ADDR_LIMIT[1:0]) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    lruc_ctrl u_ctrl (
        .aclk, .aresetn,
        .s_valid(s_tvalid), .s_ready(s_tready),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .cmd, .sts, .status
    );

    lruc_datapath #(
        .CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .HANDLE_BITS(HANDLE_BITS)
    ) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .in_func(s_tdata[FUNC_W-1:0]),
        .in_key(s_tdata[FUNC_W +: KEY_BITS]),
        .in_handle(s_tdata[FUNC_W+KEY_BITS +: HANDLE_BITS]),
        .limit(limit_reg),
        .rd_value, .ev_key, .ev_count, .occupancy
    );

    assign m_tdata = {1'b0, occupancy, ev_count, ev_key, (ev_count != '0), rd_value, status};

endmodule
